>>> rtl/core/fmbs_pkg.sv
// ----------------------------------------------------------------------------
// fmbs_pkg
// Shared types and constants of the FM-index backward search core: table
// sizes, function codes, the queued word format and the result format.
// ----------------------------------------------------------------------------
package fmbs_pkg;

  // Table geometry.
  localparam int unsigned TextRows  = 1024;
  localparam int unsigned RowW      = $clog2(TextRows);
  localparam int unsigned CntW      = RowW + 1;
  localparam int unsigned SumW      = CntW + 1;
  localparam int unsigned AlphaSize = 4;
  localparam int unsigned CodeW     = $clog2(AlphaSize);
  localparam int unsigned SymW      = 3;
  localparam int unsigned FuncW     = 2;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth    = 2;

  // Result kinds.
  localparam logic KindStep = 1'b0;
  localparam logic KindRead = 1'b1;

  // Function codes on the command port.
  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // Operations after classification by the front.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_STEP_FIRST,
    OP_STEP_NEXT,
    OP_STEP_BAD,
    OP_READ
  } op_e;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RANGE,
    BS_MATCH
  } bstate_e;

  // One row of the cumulative occurrence table.
  typedef logic [AlphaSize-1:0][CntW-1:0] occ_row_t;

  // Word held in the queue.
  typedef struct packed {
    op_e             op;
    logic [CodeW-1:0] code;
    logic            code_ok;
    logic            restart;
    logic [RowW-1:0] suffix_pos;
    logic [RowW-1:0] match_index;
  } item_t;

  // Result word.
  typedef struct packed {
    logic            kind;
    logic            found;
    logic [RowW-1:0] range_start;
    logic [RowW-1:0] range_end;
    logic [CntW-1:0] match_count;
    logic [RowW-1:0] text_position;
  } result_t;

endpackage

>>> rtl/core/fm_index_backward_search_core.sv
// ----------------------------------------------------------------------------
// fm_index_backward_search_core
// FM-index backward search engine: loads BWT rows with their suffix array
// values, narrows the row range one pattern symbol at a time and reads back
// the text positions of matches.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Ports
//  command   start_i, busy_o        func_i symbol_i suffix_pos_i starts_run_i
//                                   match_index_i
//  result    done_o (one cycle)     kind_o found_o range_start_o range_end_o
//                                   match_count_o text_position_o
//
// A word that is taken enters the queue, and the back end pops it when it is idle;
// the result strobe and word are registered from the back end's last state. Most
// words finish in the idle state; a continuing symbol of a live pattern and a
// match read that hits pass through BS_RANGE or BS_MATCH, bound by the registered
// occurrence table and suffix store reads. busy_o is high only while the two-word
// queue is full; results cannot be held off. Reset clears the control state and the symbol totals, not the tables.
// ----------------------------------------------------------------------------
module fm_index_backward_search_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [fmbs_pkg::FuncW-1:0]  func_i,
  input  logic [fmbs_pkg::SymW-1:0]   symbol_i,
  input  logic [fmbs_pkg::RowW-1:0]   suffix_pos_i,
  input  logic                        starts_run_i,
  input  logic [fmbs_pkg::RowW-1:0]   match_index_i,
  output logic                        done_o,
  output logic                        kind_o,
  output logic                        found_o,
  output logic [fmbs_pkg::RowW-1:0]   range_start_o,
  output logic [fmbs_pkg::RowW-1:0]   range_end_o,
  output logic [fmbs_pkg::CntW-1:0]   match_count_o,
  output logic [fmbs_pkg::RowW-1:0]   text_position_o
);

  logic              q_full, q_push, q_valid, q_pop;
  fmbs_pkg::item_t   push_item, pop_item;
  fmbs_pkg::result_t result;

  // Front end: accept and classify.
  fmbs_front u_front (
    .start_i       (start_i),
    .func_i        (func_i),
    .symbol_i      (symbol_i),
    .suffix_pos_i  (suffix_pos_i),
    .starts_run_i  (starts_run_i),
    .match_index_i (match_index_i),
    .q_full_i      (q_full),
    .busy_o        (busy_o),
    .push_o        (q_push),
    .item_o        (push_item)
  );

  // Queue between the two halves.
  fmbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // Back end: tables, range update and match reads.
  fmbs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (pop_item),
    .pop_o    (q_pop),
    .done_o   (done_o),
    .result_o (result)
  );

  // Result word onto its ports.
  assign kind_o          = result.kind;
  assign found_o         = result.found;
  assign range_start_o   = result.range_start;
  assign range_end_o     = result.range_end;
  assign match_count_o   = result.match_count;
  assign text_position_o = result.text_position;

endmodule

>>> rtl/core/fmbs_front.sv
// ----------------------------------------------------------------------------
// fmbs_front
// Command front end: takes a word when the queue has room and classifies it
// into a load, a pattern step (first, continuing or invalid symbol) or a
// match read. Words with the unused function code are dropped here.
// ----------------------------------------------------------------------------
module fmbs_front (
  input  logic                         start_i,
  input  logic [fmbs_pkg::FuncW-1:0]   func_i,
  input  logic [fmbs_pkg::SymW-1:0]    symbol_i,
  input  logic [fmbs_pkg::RowW-1:0]    suffix_pos_i,
  input  logic                         starts_run_i,
  input  logic [fmbs_pkg::RowW-1:0]    match_index_i,
  input  logic                         q_full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output fmbs_pkg::item_t              item_o
);

  logic accept;
  logic code_ok;

  // A word is taken whenever the queue has a free slot.
  assign busy_o  = q_full_i;
  assign accept  = start_i & ~q_full_i;
  assign code_ok = (symbol_i < fmbs_pkg::SymW'(fmbs_pkg::AlphaSize));

  // Classify the word and decide whether it needs the back end at all.
  always_comb begin
    item_o.code        = symbol_i[fmbs_pkg::CodeW-1:0];
    item_o.code_ok     = code_ok;
    item_o.restart     = starts_run_i;
    item_o.suffix_pos  = suffix_pos_i;
    item_o.match_index = match_index_i;
    item_o.op          = fmbs_pkg::OP_LOAD;
    push_o             = 1'b0;
    case (fmbs_pkg::func_e'(func_i))
      fmbs_pkg::FUNC_LOAD: begin
        item_o.op = fmbs_pkg::OP_LOAD;
        push_o    = accept;
      end
      fmbs_pkg::FUNC_STEP: begin
        if (!code_ok) begin
          item_o.op = fmbs_pkg::OP_STEP_BAD;
        end else if (starts_run_i) begin
          item_o.op = fmbs_pkg::OP_STEP_FIRST;
        end else begin
          item_o.op = fmbs_pkg::OP_STEP_NEXT;
        end
        push_o = accept;
      end
      fmbs_pkg::FUNC_READ: begin
        item_o.op = fmbs_pkg::OP_READ;
        push_o    = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/fmbs_queue.sv
// ----------------------------------------------------------------------------
// fmbs_queue
// Small first-in first-out queue of classified words between the front end
// and the back end.
// ----------------------------------------------------------------------------
module fmbs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fmbs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fmbs_pkg::item_t item_o
);

  localparam int unsigned PtrW = (fmbs_pkg::QDepth > 1) ? $clog2(fmbs_pkg::QDepth) : 1;
  localparam int unsigned FillW = $clog2(fmbs_pkg::QDepth + 1);

  fmbs_pkg::item_t  slot_q [fmbs_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(fmbs_pkg::QDepth));
  assign valid_o = (fill_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(fmbs_pkg::QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(fmbs_pkg::QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/fmbs_back.sv
// ----------------------------------------------------------------------------
// fmbs_back
// Back end: holds the occurrence table, the suffix store and the symbol
// totals, loads rows, narrows the search range and answers match reads.
// Results leave through a registered output word with a one-cycle strobe.
// ----------------------------------------------------------------------------
module fmbs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fmbs_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              done_o,
  output fmbs_pkg::result_t result_o
);

  localparam logic [fmbs_pkg::CntW-1:0] RowsCnt = fmbs_pkg::CntW'(fmbs_pkg::TextRows);
  localparam logic [fmbs_pkg::SumW-1:0] LastRow = fmbs_pkg::SumW'(fmbs_pkg::TextRows - 1);

  fmbs_pkg::bstate_e state_q, state_d;

  logic                          alive_q, alive_d;
  logic [fmbs_pkg::RowW-1:0]     start_q, start_d;
  logic [fmbs_pkg::RowW-1:0]     end_q, end_d;
  logic [fmbs_pkg::CntW-1:0]     load_cnt_q, load_cnt_d;
  fmbs_pkg::occ_row_t            totals_q, totals_d;
  logic [fmbs_pkg::CodeW-1:0]    code_q, code_d;
  logic                          done_q, done_d;
  fmbs_pkg::result_t             res_q, res_d;

  // Memories and their ports.
  fmbs_pkg::occ_row_t            occ_mem [fmbs_pkg::TextRows];
  logic [fmbs_pkg::RowW-1:0]     sfx_mem [fmbs_pkg::TextRows];
  logic                          occ_we, sfx_we;
  logic [fmbs_pkg::RowW-1:0]     wr_addr;
  fmbs_pkg::occ_row_t            occ_wdata;
  logic [fmbs_pkg::RowW-1:0]     occ_raddr_lo, occ_raddr_hi, sfx_raddr;
  fmbs_pkg::occ_row_t            occ_lo_q, occ_hi_q;
  logic [fmbs_pkg::RowW-1:0]     sfx_rdata_q;

  // Range unit signals.
  logic [fmbs_pkg::CodeW-1:0]    rng_code;
  logic [fmbs_pkg::CntW-1:0]     rng_lo, rng_hi;
  logic [fmbs_pkg::SumW-1:0]     rng_base, rng_s, rng_e_raw, rng_e;
  logic                          rng_ok;

  logic                          pop;
  logic                          read_hit;
  logic [fmbs_pkg::CntW-1:0]     load_row;
  fmbs_pkg::occ_row_t            totals_new;
  logic                          emit, emit_kind, read_miss;
  logic [fmbs_pkg::RowW-1:0]     emit_pos;

  assign pop    = (state_q == fmbs_pkg::BS_IDLE) && valid_i;
  assign pop_o  = pop;
  assign done_o = done_q;
  assign result_o = res_q;

  // A match read hits when the pattern is alive and the index lies in range.
  assign read_hit = alive_q && (item_i.match_index <= (end_q - start_q));

  // Read addresses: the row before the range, the last row of the range, and the match row.
  assign occ_raddr_lo = start_q - fmbs_pkg::RowW'(1);
  assign occ_raddr_hi = end_q;
  assign sfx_raddr    = start_q + item_i.match_index;

  // Operands of the range unit come from the table reads when continuing a
  // pattern, and from the symbol totals when a pattern begins.
  always_comb begin
    if (state_q == fmbs_pkg::BS_RANGE) begin
      rng_code = code_q;
      rng_lo   = (start_q == '0) ? '0 : occ_lo_q[code_q];
      rng_hi   = occ_hi_q[code_q];
    end else begin
      rng_code = item_i.code;
      rng_lo   = '0;
      rng_hi   = totals_q[item_i.code];
    end
  end

  // First-column base: one for the sentinel plus the totals of smaller codes,
  // then the new range, clamped to the last row of the table.
  always_comb begin
    rng_base = fmbs_pkg::SumW'(1);
    for (int k = 0; k < fmbs_pkg::AlphaSize; k++) begin
      if (fmbs_pkg::CodeW'(k) < rng_code) begin
        rng_base = rng_base + fmbs_pkg::SumW'(totals_q[k]);
      end
    end
    rng_s     = rng_base + fmbs_pkg::SumW'(rng_lo);
    rng_e_raw = rng_base + fmbs_pkg::SumW'(rng_hi) - fmbs_pkg::SumW'(1);
    rng_e     = (rng_e_raw > LastRow) ? LastRow : rng_e_raw;
    rng_ok    = (rng_hi > rng_lo) && (rng_s <= rng_e);
  end

  // Totals after a load, including a restart.
  always_comb begin
    load_row   = item_i.restart ? '0 : load_cnt_q;
    totals_new = item_i.restart ? '0 : totals_q;
    if (item_i.code_ok) begin
      totals_new[item_i.code] = totals_new[item_i.code] + fmbs_pkg::CntW'(1);
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmbs_pkg::BS_IDLE: begin
        if (pop) begin
          if ((item_i.op == fmbs_pkg::OP_STEP_NEXT) && alive_q) begin
            state_d = fmbs_pkg::BS_RANGE;
          end else if ((item_i.op == fmbs_pkg::OP_READ) && read_hit) begin
            state_d = fmbs_pkg::BS_MATCH;
          end
        end
      end
      fmbs_pkg::BS_RANGE: state_d = fmbs_pkg::BS_IDLE;
      fmbs_pkg::BS_MATCH: state_d = fmbs_pkg::BS_IDLE;
      default:            state_d = fmbs_pkg::BS_IDLE;
    endcase
  end

  // Datapath updates and result formation.
  always_comb begin
    alive_d    = alive_q;
    start_d    = start_q;
    end_d      = end_q;
    load_cnt_d = load_cnt_q;
    totals_d   = totals_q;
    code_d     = code_q;
    done_d     = 1'b0;
    res_d      = res_q;
    occ_we     = 1'b0;
    sfx_we     = 1'b0;
    wr_addr    = load_row[fmbs_pkg::RowW-1:0];
    occ_wdata  = totals_new;
    emit       = 1'b0;
    emit_kind  = fmbs_pkg::KindStep;
    read_miss  = 1'b0;
    emit_pos   = '0;

    case (state_q)
      fmbs_pkg::BS_IDLE: begin
        if (pop) begin
          code_d = item_i.code;
          case (item_i.op)
            fmbs_pkg::OP_LOAD: begin
              // A load into a full table is ignored entirely.
              if (load_row < RowsCnt) begin
                totals_d   = totals_new;
                occ_we     = 1'b1;
                sfx_we     = 1'b1;
                load_cnt_d = load_row + fmbs_pkg::CntW'(1);
                alive_d    = 1'b0;
                start_d    = '0;
                end_d      = '0;
              end
            end
            fmbs_pkg::OP_STEP_FIRST: begin
              alive_d = rng_ok;
              start_d = rng_ok ? rng_s[fmbs_pkg::RowW-1:0] : '0;
              end_d   = rng_ok ? rng_e[fmbs_pkg::RowW-1:0] : '0;
              emit    = 1'b1;
            end
            fmbs_pkg::OP_STEP_NEXT: begin
              // A live pattern waits for its table reads; a dead one reports.
              if (!alive_q) begin
                start_d = '0;
                end_d   = '0;
                emit    = 1'b1;
              end
            end
            fmbs_pkg::OP_STEP_BAD: begin
              alive_d = 1'b0;
              start_d = '0;
              end_d   = '0;
              emit    = 1'b1;
            end
            fmbs_pkg::OP_READ: begin
              if (!read_hit) begin
                emit      = 1'b1;
                emit_kind = fmbs_pkg::KindRead;
                read_miss = 1'b1;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      fmbs_pkg::BS_RANGE: begin
        alive_d = rng_ok;
        start_d = rng_ok ? rng_s[fmbs_pkg::RowW-1:0] : '0;
        end_d   = rng_ok ? rng_e[fmbs_pkg::RowW-1:0] : '0;
        emit    = 1'b1;
      end
      fmbs_pkg::BS_MATCH: begin
        emit      = 1'b1;
        emit_kind = fmbs_pkg::KindRead;
        emit_pos  = sfx_rdata_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // The result reports the range as it stands after this word.
    if (emit) begin
      done_d              = 1'b1;
      res_d.kind          = emit_kind;
      res_d.found         = alive_d & ~read_miss;
      res_d.range_start   = alive_d ? start_d : '0;
      res_d.range_end     = alive_d ? end_d : '0;
      res_d.match_count   = alive_d ? (fmbs_pkg::CntW'(end_d) - fmbs_pkg::CntW'(start_d)
                                       + fmbs_pkg::CntW'(1)) : '0;
      res_d.text_position = emit_pos;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fmbs_pkg::BS_IDLE;
      alive_q    <= 1'b0;
      start_q    <= '0;
      end_q      <= '0;
      load_cnt_q <= '0;
      totals_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      alive_q    <= alive_d;
      start_q    <= start_d;
      end_q      <= end_d;
      load_cnt_q <= load_cnt_d;
      totals_q   <= totals_d;
      done_q     <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    res_q  <= res_d;
  end

  // Occurrence table: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wdata;
    end
    occ_lo_q <= occ_mem[occ_raddr_lo];
    occ_hi_q <= occ_mem[occ_raddr_hi];
  end

  // Suffix store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (sfx_we) begin
      sfx_mem[wr_addr] <= item_i.suffix_pos;
    end
    sfx_rdata_q <= sfx_mem[sfx_raddr];
  end

endmodule

>>> test/tb_fm_index_backward_search_core.sv
// ----------------------------------------------------------------------------
// tb_fm_index_backward_search_core
// Self-checking bench for the FM-index backward search core. Suffix orders of
// small random texts are sorted here and loaded as BWT rows. Patterns taken
// from the text, random patterns and malformed words are then searched and
// read back. A full table is also loaded, to reach the clamp at the end of
// the table and the ignored loads past it. A scoreboard keeps its own copy of
// the index and predicts every result word in order.
// ----------------------------------------------------------------------------
module tb_fm_index_backward_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Symbol codes that are not part of the alphabet.
  localparam int SentinelCode = 4;
  localparam int TopSymCode   = (1 << fmbs_pkg::SymW) - 1;

  // Sender idle share per phase. Results cannot be held off, so the phase
  // meant for receiver stalls runs without sender idling.
  localparam int PhaseIdle [4] = '{0, 57, 0, 23};

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the index and the search range, and the
  // queue of result words still awaited.
  // --------------------------------------------------------------------------
  class range_scoreboard;
    logic [fmbs_pkg::CntW-1:0] occ_cnt [fmbs_pkg::TextRows][fmbs_pkg::AlphaSize];
    logic [fmbs_pkg::RowW-1:0] sa_val [fmbs_pkg::TextRows];
    bit                        row_loaded [fmbs_pkg::TextRows];
    logic [fmbs_pkg::CntW-1:0] sym_total [fmbs_pkg::AlphaSize];
    int unsigned               rows_held;
    int unsigned               lo_row;
    int unsigned               hi_row;
    bit                        live;
    fmbs_pkg::result_t         awaited [$];
    int unsigned               fault_count;

    function new();
      foreach (sym_total[k]) sym_total[k] = '0;
      rows_held   = 0;
      fault_count = 0;
      drop_match();
    endfunction

    function void drop_match();
      live   = 1'b0;
      lo_row = 0;
      hi_row = 0;
    endfunction

    function void log_fault(string text);
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: %s", $time, text);
      end
    endfunction

    // The F-column block of a symbol starts after the sentinel row and the
    // blocks of all smaller symbols; the end is clamped to the last row.
    function void narrow_to(int unsigned code, int unsigned lo, int unsigned hi);
      int unsigned base;
      int unsigned s;
      int unsigned e;
      int unsigned k;
      base = 1;
      for (k = 0; k < code; k++) base += sym_total[k];
      s = base + lo;
      e = base + hi - 1;
      if (e > fmbs_pkg::TextRows - 1) e = fmbs_pkg::TextRows - 1;
      if (s > e) begin
        drop_match();
      end else begin
        lo_row = s;
        hi_row = e;
        live   = 1'b1;
      end
    endfunction

    function fmbs_pkg::result_t status_word(logic kind, logic [fmbs_pkg::RowW-1:0] pos);
      fmbs_pkg::result_t w;
      w.kind          = kind;
      w.found         = live;
      w.range_start   = live ? fmbs_pkg::RowW'(lo_row) : '0;
      w.range_end     = live ? fmbs_pkg::RowW'(hi_row) : '0;
      w.match_count   = live ? fmbs_pkg::CntW'(hi_row - lo_row + 1) : '0;
      w.text_position = pos;
      return w;
    endfunction

    // Keeps the stimulus away from table rows that were never loaded: a
    // continuing step turns into a first step, a read goes out of range.
    function void keep_to_loaded(input logic [fmbs_pkg::FuncW-1:0] f,
                                 input logic [fmbs_pkg::SymW-1:0] s,
                                 inout logic r, inout logic [fmbs_pkg::RowW-1:0] m);
      if (!live) return;
      if (f == fmbs_pkg::FUNC_STEP && s < fmbs_pkg::AlphaSize && !r) begin
        if (!row_loaded[hi_row] || (lo_row > 0 && !row_loaded[lo_row-1])) r = 1'b1;
      end else if (f == fmbs_pkg::FUNC_READ && m <= hi_row - lo_row) begin
        if (!row_loaded[lo_row+m]) m = '1;
      end
    endfunction

    // Updates the copy of the index for an accepted word and queues the
    // result it causes.
    function void note_word(logic [fmbs_pkg::FuncW-1:0] f, logic [fmbs_pkg::SymW-1:0] s,
                            logic [fmbs_pkg::RowW-1:0] p, logic r,
                            logic [fmbs_pkg::RowW-1:0] m);
      fmbs_pkg::result_t res;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       k;
      case (fmbs_pkg::func_e'(f))
        fmbs_pkg::FUNC_LOAD: begin
          if (r) begin
            foreach (sym_total[j]) sym_total[j] = '0;
            rows_held = 0;
          end
          // A full table ignores the load and leaves the pattern alone.
          if (rows_held < fmbs_pkg::TextRows) begin
            if (s < fmbs_pkg::AlphaSize) sym_total[s] += 1;
            for (k = 0; k < fmbs_pkg::AlphaSize; k++) occ_cnt[rows_held][k] = sym_total[k];
            sa_val[rows_held]     = p;
            row_loaded[rows_held] = 1'b1;
            rows_held++;
            drop_match();
          end
        end
        fmbs_pkg::FUNC_STEP: begin
          if (s >= fmbs_pkg::AlphaSize) begin
            drop_match();
          end else if (r) begin
            if (sym_total[s] == 0) drop_match();
            else narrow_to(s, 0, sym_total[s]);
          end else if (live) begin
            lo = (lo_row == 0) ? 0 : occ_cnt[lo_row-1][s];
            hi = occ_cnt[hi_row][s];
            if (hi <= lo) drop_match();
            else narrow_to(s, lo, hi);
          end else begin
            drop_match();
          end
          awaited = {awaited, status_word(fmbs_pkg::KindStep, '0)};
        end
        fmbs_pkg::FUNC_READ: begin
          if (live && m <= hi_row - lo_row) begin
            res = status_word(fmbs_pkg::KindRead, sa_val[lo_row+m]);
          end else begin
            res       = status_word(fmbs_pkg::KindRead, '0);
            res.found = 1'b0;
          end
          awaited = {awaited, res};
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [fmbs_pkg::CntW-1:0] want,
                                logic [fmbs_pkg::CntW-1:0] got);
      if (got !== want) begin
        log_fault($sformatf("%s differs: expected %0d, got %0d", name, want, got));
      end
    endfunction

    function void check_word(fmbs_pkg::result_t got);
      fmbs_pkg::result_t want;
      if (awaited.size() == 0) begin
        log_fault($sformatf("result word with nothing awaited: %p", got));
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("found", want.found, got.found);
      compare_field("range_start", want.range_start, got.range_start);
      compare_field("range_end", want.range_end, got.range_end);
      compare_field("match_count", want.match_count, got.match_count);
      compare_field("text_position", want.text_position, got.text_position);
    endfunction

    function void flush_awaited();
      while (awaited.size() > 0) begin
        log_fault($sformatf("result word never arrived: %p", awaited.pop_front()));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its signals.
  // --------------------------------------------------------------------------
  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       start_i       = 1'b0;
  logic                       busy_o;
  logic [fmbs_pkg::FuncW-1:0] func_i        = '0;
  logic [fmbs_pkg::SymW-1:0]  symbol_i      = '0;
  logic [fmbs_pkg::RowW-1:0]  suffix_pos_i  = '0;
  logic                       starts_run_i  = 1'b0;
  logic [fmbs_pkg::RowW-1:0]  match_index_i = '0;
  logic                       done_o;
  logic                       kind_o;
  logic                       found_o;
  logic [fmbs_pkg::RowW-1:0]  range_start_o;
  logic [fmbs_pkg::RowW-1:0]  range_end_o;
  logic [fmbs_pkg::CntW-1:0]  match_count_o;
  logic [fmbs_pkg::RowW-1:0]  text_position_o;

  range_scoreboard sb = new();
  int              idle_pct = 0;
  int unsigned     words_sent = 0;
  int              txt [0:63];
  int              ord [0:64];

  fm_index_backward_search_core u_dut (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every result word is checked at the edge that ends its strobe cycle.
  always @(posedge clk_i) begin : watch_results
    fmbs_pkg::result_t seen;
    seen.kind          = kind_o;
    seen.found         = found_o;
    seen.range_start   = range_start_o;
    seen.range_end     = range_end_o;
    seen.match_count   = match_count_o;
    seen.text_position = text_position_o;
    if (rst_ni && done_o) sb.check_word(seen);
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving. Tasks are entered and left at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input int f, input int s, input int p, input int r,
                           input int m);
    logic [fmbs_pkg::FuncW-1:0] fv;
    logic [fmbs_pkg::SymW-1:0]  sv;
    logic [fmbs_pkg::RowW-1:0]  pv;
    logic                       run;
    logic [fmbs_pkg::RowW-1:0]  idx;
    fv  = fmbs_pkg::FuncW'(f);
    sv  = fmbs_pkg::SymW'(s);
    pv  = fmbs_pkg::RowW'(p);
    run = (r != 0);
    idx = fmbs_pkg::RowW'(m);
    sb.keep_to_loaded(fv, sv, run, idx);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    start_i       = 1'b1;
    func_i        = fv;
    symbol_i      = sv;
    suffix_pos_i  = pv;
    starts_run_i  = run;
    match_index_i = idx;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(fv, sv, pv, run, idx);
    if (fv != fmbs_pkg::FUNC_NONE) words_sent++;
    @(negedge clk_i);
  endtask

  // Suffix order with the sentinel smallest: 1 if suffix a sorts after b.
  function automatic bit suffix_after(int a, int b);
    int k;
    int ra;
    int rb;
    for (k = 0; k < 64; k++) begin
      ra = (txt[a+k] == SentinelCode) ? 0 : txt[a+k] + 1;
      rb = (txt[b+k] == SentinelCode) ? 0 : txt[b+k] + 1;
      if (ra != rb) return ra > rb;
    end
    return 1'b0;
  endfunction

  // Sorts the suffixes of txt[0..n-1] and loads the BWT rows, optionally
  // breaking off early.
  task automatic load_text(input int n, input bit truncate);
    int i;
    int j;
    int key;
    int cut_at;
    txt[n] = SentinelCode;
    for (i = 0; i <= n; i++) ord[i] = i;
    for (i = 1; i <= n; i++) begin
      key = ord[i];
      j   = i - 1;
      while (j >= 0 && suffix_after(ord[j], key)) begin
        ord[j+1] = ord[j];
        j--;
      end
      ord[j+1] = key;
    end
    cut_at = truncate ? $urandom_range(n, 1) : n + 1;
    for (i = 0; i < cut_at; i++) begin
      send_word(fmbs_pkg::FUNC_LOAD, (ord[i] == 0) ? SentinelCode : txt[ord[i]-1], ord[i],
                i == 0, $urandom_range(fmbs_pkg::TextRows-1));
    end
  endtask

  // Match reads, mostly near the current range.
  task automatic read_some(input int cnt);
    int m;
    repeat (cnt) begin
      if (sb.live && $urandom_range(7) != 0) m = $urandom_range(sb.hi_row - sb.lo_row + 1);
      else m = $urandom_range(fmbs_pkg::TextRows-1);
      send_word(fmbs_pkg::FUNC_READ, $urandom_range(TopSymCode),
                $urandom_range(fmbs_pkg::TextRows-1), $urandom_range(1), m);
    end
  endtask

  // One pattern fed last symbol first, from the text or at random.
  task automatic run_pattern(input int n, input bit from_text);
    int len;
    int p;
    int j;
    int pat [0:7];
    len = from_text ? $urandom_range((n < 5) ? n : 5, 1) : $urandom_range(5, 1);
    p   = from_text ? $urandom_range(n - len) : 0;
    for (j = 0; j < len; j++) begin
      pat[j] = from_text ? txt[p+j] : $urandom_range(fmbs_pkg::AlphaSize-1);
    end
    for (j = len - 1; j >= 0; j--) begin
      send_word(fmbs_pkg::FUNC_STEP, pat[j], $urandom_range(fmbs_pkg::TextRows-1),
                j == len - 1, $urandom_range(fmbs_pkg::TextRows-1));
      if ($urandom_range(3) == 0) read_some(1);
    end
    read_some($urandom_range(3, 1));
  endtask

  // Malformed or stray words.
  task automatic noise_word();
    case ($urandom_range(4))
      0: send_word(fmbs_pkg::FUNC_NONE, $urandom_range(TopSymCode),
                   $urandom_range(fmbs_pkg::TextRows-1), $urandom_range(1),
                   $urandom_range(fmbs_pkg::TextRows-1));
      1: send_word(fmbs_pkg::FUNC_STEP, $urandom_range(TopSymCode, SentinelCode),
                   $urandom_range(fmbs_pkg::TextRows-1), $urandom_range(1),
                   $urandom_range(fmbs_pkg::TextRows-1));
      2: send_word(fmbs_pkg::FUNC_LOAD, $urandom_range(TopSymCode),
                   $urandom_range(fmbs_pkg::TextRows-1), 1'b0,
                   $urandom_range(fmbs_pkg::TextRows-1));
      3: send_word(fmbs_pkg::FUNC_READ, $urandom_range(TopSymCode),
                   $urandom_range(fmbs_pkg::TextRows-1), $urandom_range(1),
                   $urandom_range(fmbs_pkg::TextRows-1));
      default: send_word(fmbs_pkg::FUNC_STEP, $urandom_range(fmbs_pkg::AlphaSize-1),
                         $urandom_range(fmbs_pkg::TextRows-1), 1'b0,
                         $urandom_range(fmbs_pkg::TextRows-1));
    endcase
  endtask

  // A fresh random text followed by several searches.
  task automatic run_episode();
    int n;
    int amax;
    int i;
    n    = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    amax = ($urandom_range(3) == 0) ? $urandom_range(fmbs_pkg::AlphaSize-2)
                                    : fmbs_pkg::AlphaSize - 1;
    for (i = 0; i < n; i++) txt[i] = $urandom_range(amax);
    load_text(n, $urandom_range(15) == 0);
    repeat ($urandom_range(5, 2)) begin
      if ($urandom_range(6) == 0) noise_word();
      run_pattern(n, $urandom_range(3) != 0);
    end
  endtask

  // Fills every row. Only the highest code sits in the last two rows, so its
  // block runs past the end of the table and is clamped.
  task automatic load_full_table();
    int i;
    for (i = 0; i < fmbs_pkg::TextRows; i++) begin
      send_word(fmbs_pkg::FUNC_LOAD, (i >= fmbs_pkg::TextRows - 2) ? fmbs_pkg::AlphaSize - 1
                                     : $urandom_range(fmbs_pkg::AlphaSize-2),
                $urandom_range(fmbs_pkg::TextRows-1), i == 0,
                $urandom_range(fmbs_pkg::TextRows-1));
    end
    // Clamped live range of one row, then a start beyond the clamped end.
    send_word(fmbs_pkg::FUNC_STEP, fmbs_pkg::AlphaSize - 1, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 1);
    send_word(fmbs_pkg::FUNC_STEP, fmbs_pkg::AlphaSize - 1, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b0, 0);
    // Loads into a full table are dropped and the pattern survives them.
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_LOAD, $urandom_range(TopSymCode),
              $urandom_range(fmbs_pkg::TextRows-1), 1'b0, 0);
    read_some(2);
    send_word(fmbs_pkg::FUNC_LOAD, $urandom_range(TopSymCode),
              $urandom_range(fmbs_pkg::TextRows-1), 1'b0, 0);
    repeat (12) run_pattern(0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int unsigned budget;
    int waited;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: searches before any load, a stray code.
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_STEP, 2, fmbs_pkg::TextRows - 1, 1'b0, fmbs_pkg::TextRows - 1);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_NONE, TopSymCode, fmbs_pkg::TextRows - 1, 1'b1,
              fmbs_pkg::TextRows - 1);

    // A small fixed text, then a pattern that hits once.
    txt[0] = 2; txt[1] = 0; txt[2] = 1; txt[3] = 0; txt[4] = 3;
    load_text(5, 1'b0);
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_STEP, 2, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 1);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, fmbs_pkg::TextRows - 1);
    // Sentinel in a pattern, then a step while dead.
    send_word(fmbs_pkg::FUNC_STEP, SentinelCode, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b0, 0);
    // A pattern that runs empty, and a read after it.
    send_word(fmbs_pkg::FUNC_STEP, 3, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_STEP, 3, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_STEP, TopSymCode, 0, 1'b1, 0);
    // A load of an unknown code ends the live pattern.
    send_word(fmbs_pkg::FUNC_STEP, 1, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_LOAD, SentinelCode + 1, fmbs_pkg::TextRows - 1, 1'b0, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 0);
    // Last valid match of a two-row range.
    send_word(fmbs_pkg::FUNC_STEP, 0, 0, 1'b1, 0);
    send_word(fmbs_pkg::FUNC_READ, 0, 0, 1'b0, 1);

    // Random phases with different sender idling.
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = PhaseIdle[ph];
      if (ph == 3) load_full_table();
      budget = words_sent + ((ph == 3) ? 150 : 225);
      while (words_sent < budget) run_episode();
    end
    start_i = 1'b0;

    // Drain the outstanding results, then give the block a little longer.
    waited = 0;
    while (sb.awaited.size() > 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    sb.flush_awaited();

    if (sb.fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fmbs_pkg.sv
rtl/core/fmbs_front.sv
rtl/core/fmbs_queue.sv
rtl/core/fmbs_back.sv
rtl/core/fm_index_backward_search_core.sv
test/tb_fm_index_backward_search_core.sv
